[rtl/idea_pkg.sv]
// Package with the round key ROM and the modular arithmetic helpers of the cipher core.
package idea_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned BlockW  = 64;
  localparam int unsigned ProdW   = 33;
  localparam int unsigned RomSize = 56;
  localparam int unsigned KeysPerRound = 6;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [BlockW-1:0] block_t;
  typedef logic [ProdW-1:0]  prod_t;

  localparam word_t RoundKeyRom [RomSize] = '{
    16'd12643, 16'd25650, 16'd12644, 16'd13156, 16'd13619, 16'd25136, 16'd13414,
    16'd14691, 16'd25698, 16'd51302, 16'd51306, 16'd26308, 16'd24680, 16'd52338,
    16'd50786, 16'd50888, 16'd52624, 16'd54477, 16'd35008, 16'd53656, 16'd58764,
    16'd50573, 16'd37064, 16'd50576, 16'd39697, 16'd33187, 16'd12747, 16'd6539,
    16'd6945,  16'd37259, 16'd8603,  16'd8617,  16'd18019, 16'd38451, 16'd5686,
    16'd17187, 16'd5699,  16'd13891, 16'd21302, 16'd8963,  16'd26156, 16'd27782,
    16'd17964, 16'd34412, 16'd34470, 16'd27718, 16'd1676,  16'd50988, 16'd3212,
    16'd22796, 16'd55565, 16'd19672, 16'd16582, 16'd28874, 16'd19287, 16'd56017
  };

  // Raw product of two operands, zero standing for 65536.
  function automatic prod_t mul_raw(word_t x, word_t y);
    logic [16:0] ox;
    logic [16:0] oy;
    logic [33:0] p;
    ox = (x == '0) ? 17'h10000 : {1'b0, x};
    oy = (y == '0) ? 17'h10000 : {1'b0, y};
    p  = ox * oy;
    return p[ProdW-1:0];
  endfunction

  // Reduce a raw product modulo 65537: low half minus high half, fold once.
  function automatic word_t mod_red(prod_t p);
    logic [17:0] diff;
    diff = {2'b00, p[15:0]} - {1'b0, p[32:16]};
    if (diff[17]) begin
      diff = diff + 18'd65537;
    end
    return diff[15:0];
  endfunction

endpackage

[rtl/idea_blk_if.sv]
// Valid/ready channel that carries one 64-bit cipher block.
interface idea_blk_if;
  logic                 valid;
  logic                 ready;
  idea_pkg::block_t     block;

  modport source (output valid, output block, input ready);
  modport sink   (input valid, input block, output ready);
endinterface

[rtl/idea_round.sv]
// One cipher round as four register stages: key multiplies, then two mix multiplies, then output mix.
module idea_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  idea_pkg::block_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output idea_pkg::block_t data_o
);

  localparam int unsigned Base = idea_pkg::KeysPerRound * ROUND;
  localparam idea_pkg::word_t K0 = idea_pkg::RoundKeyRom[(Base + 0) % idea_pkg::RomSize];
  localparam idea_pkg::word_t K1 = idea_pkg::RoundKeyRom[(Base + 1) % idea_pkg::RomSize];
  localparam idea_pkg::word_t K2 = idea_pkg::RoundKeyRom[(Base + 2) % idea_pkg::RomSize];
  localparam idea_pkg::word_t K3 = idea_pkg::RoundKeyRom[(Base + 3) % idea_pkg::RomSize];
  localparam idea_pkg::word_t K4 = idea_pkg::RoundKeyRom[(Base + 4) % idea_pkg::RomSize];
  localparam idea_pkg::word_t K5 = idea_pkg::RoundKeyRom[(Base + 5) % idea_pkg::RomSize];

  logic [3:0] v_q;
  logic [3:0] rdy;

  idea_pkg::prod_t pa_q, pd_q, pe_q, pf_q;
  idea_pkg::word_t b1_q, c1_q;
  idea_pkg::word_t a2_q, b2_q, c2_q, d2_q;
  idea_pkg::word_t a3_q, b3_q, c3_q, d3_q, e3_q;
  idea_pkg::block_t out_q;

  idea_pkg::word_t a2_d, d2_d, e3_d, f4_d, g4_d, mix3_d;

  // A stage takes new data when it is empty or its successor takes its word.
  assign rdy[3]  = !v_q[3] || ready_i;
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  assign a2_d   = idea_pkg::mod_red(pa_q);
  assign d2_d   = idea_pkg::mod_red(pd_q);
  assign e3_d   = idea_pkg::mod_red(pe_q);
  assign mix3_d = (b2_q ^ d2_q) + e3_d;
  assign f4_d   = idea_pkg::mod_red(pf_q);
  assign g4_d   = e3_q + f4_d;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      pa_q <= idea_pkg::mul_raw(data_i[63:48], K0);
      b1_q <= data_i[47:32] + K1;
      c1_q <= data_i[31:16] + K2;
      pd_q <= idea_pkg::mul_raw(data_i[15:0], K3);
    end
    if (rdy[1] && v_q[0]) begin
      a2_q <= a2_d;
      b2_q <= b1_q;
      c2_q <= c1_q;
      d2_q <= d2_d;
      pe_q <= idea_pkg::mul_raw(a2_d ^ c1_q, K4);
    end
    if (rdy[2] && v_q[1]) begin
      a3_q <= a2_q;
      b3_q <= b2_q;
      c3_q <= c2_q;
      d3_q <= d2_q;
      e3_q <= idea_pkg::mod_red(pe_q);
      pf_q <= idea_pkg::mul_raw(mix3_d, K5);
    end
    if (rdy[3] && v_q[2]) begin
      // middle words come out swapped
      out_q <= {a3_q ^ f4_d, c3_q ^ f4_d, b3_q ^ g4_d, d3_q ^ g4_d};
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = out_q;

endmodule

[rtl/idea_round_block_encrypt.sv]
// Each round holds four register stages and four 17x17 multiplies between block and result.
// Throughput: one block per cycle while the output takes results.
// Back pressure ripples stage by stage, so empty stages keep filling while a result waits.
// Reset: rst_ni low clears every stage valid bit at once; data registers are not reset.
// No configuration and no clearing pass; the core accepts words right after reset.
module idea_round_block_encrypt #(
  parameter int unsigned NUM_ROUNDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  idea_blk_if.sink    block_in_i,
  idea_blk_if.source  block_out_o
);

  localparam int unsigned Depth = 4 * NUM_ROUNDS;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // Handshake chain between rounds: index 0 is the input, NUM_ROUNDS the output.
  logic             vld [NUM_ROUNDS+1];
  logic             rdy [NUM_ROUNDS+1];
  idea_pkg::block_t dat [NUM_ROUNDS+1];

  assign vld[0]           = block_in_i.valid;
  assign dat[0]           = block_in_i.block;
  assign block_in_i.ready = rdy[0];

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    // Each round pulls its own six keys from the ROM at fixed indexes.
    idea_round #(
      .ROUND (r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[r]),
      .ready_o (rdy[r]),
      .data_i  (dat[r]),
      .valid_o (vld[r+1]),
      .ready_i (rdy[r+1]),
      .data_o  (dat[r+1])
    );
  end

  assign block_out_o.valid     = vld[NUM_ROUNDS];
  assign block_out_o.block     = dat[NUM_ROUNDS];
  assign rdy[NUM_ROUNDS]       = block_out_o.ready;

  // Track words in flight to check the pipeline neither drops nor invents any.
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            in_fire, out_fire;

  assign in_fire  = block_in_i.valid && block_in_i.ready;
  assign out_fire = block_out_o.valid && block_out_o.ready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_fire && !out_fire) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (!in_fire && out_fire) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result only shows up for a word that went in.
  a_out_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_out_o.valid |-> inflight_q != '0)
    else $error("result word without a pending input");

  // Occupancy never exceeds the number of stages.
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(Depth))
    else $error("more words in flight than pipeline stages");

  // The input stalls only when a finished result is held at the output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !block_in_i.ready |-> block_out_o.valid && !block_out_o.ready)
    else $error("input stalled with no blocked result");

  // A full pipeline with a stalled output holds input back.
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == CntW'(Depth) && !block_out_o.ready |-> !block_in_i.ready)
    else $error("input taken while pipeline full and stalled");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the pipelined eight-round IDEA-style block encryption core.
`timescale 1ns / 100ps

module tb_top;

  // Round count of the instance; keep the predictor and the core in step.
  localparam int unsigned RoundCount = 8;
  // Pipeline depth of the core from accepted word to result word.
  localparam int unsigned PipeLatency = 4 * RoundCount;
  // Length of the single long receiver hold-off that fills the pipeline.
  localparam int unsigned HoldCycles = 300;
  // Cycles without any word taken at the input or output before the run is declared hung.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomBlocks = 1500;
  localparam int unsigned ReportLimit = 10;

  // Own copy of the round key table, so that a wrong ROM in the core shows up.
  localparam idea_pkg::word_t KeyTable [56] = '{
    16'd12643, 16'd25650, 16'd12644, 16'd13156, 16'd13619, 16'd25136, 16'd13414,
    16'd14691, 16'd25698, 16'd51302, 16'd51306, 16'd26308, 16'd24680, 16'd52338,
    16'd50786, 16'd50888, 16'd52624, 16'd54477, 16'd35008, 16'd53656, 16'd58764,
    16'd50573, 16'd37064, 16'd50576, 16'd39697, 16'd33187, 16'd12747, 16'd6539,
    16'd6945,  16'd37259, 16'd8603,  16'd8617,  16'd18019, 16'd38451, 16'd5686,
    16'd17187, 16'd5699,  16'd13891, 16'd21302, 16'd8963,  16'd26156, 16'd27782,
    16'd17964, 16'd34412, 16'd34470, 16'd27718, 16'd1676,  16'd50988, 16'd3212,
    16'd22796, 16'd55565, 16'd19672, 16'd16582, 16'd28874, 16'd19287, 16'd56017
  };

  // Directed blocks. A cipher output cannot be read off by eye, so every row
  // is checked against the predictor; the table carries stimulus only.
  localparam idea_pkg::block_t DirectedBlocks [17] = '{
    64'h0000_0000_0000_0000,  // both multiply words are zero, i.e. 65536
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFE,
    64'hFFFF_0000_FFFF_0000,  // zero in the last multiply word only
    64'h0000_FFFF_0000_FFFF,  // zero in the first multiply word only
    64'h0001_0001_0001_0001,  // multiply by one
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0123_4567_89AB_CDEF,
    64'hFEDC_BA98_7654_3210,
    64'h8000_8000_8000_8000,
    64'h7FFF_7FFF_7FFF_7FFF,
    64'h3163_6432_3164_3364,  // words equal to the first round keys
    64'h1234_9BCE_CE9C_5678,  // both first-round additions wrap to zero
    64'h0000_1234_5678_0000
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  idea_blk_if blk_in ();
  idea_blk_if blk_out ();

  idea_round_block_encrypt #(
    .NUM_ROUNDS (RoundCount)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .block_in_i  (blk_in),
    .block_out_o (blk_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ciphertexts predicted for accepted words, oldest first.
  idea_pkg::block_t expected_cipher_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;

  int unsigned error_count       = 0;
  int unsigned blocks_in         = 0;
  int unsigned blocks_checked    = 0;
  int unsigned full_stall_cycles = 0;
  int unsigned idle_cycles       = 0;
  int unsigned directed_count    = 0;

  // Multiply modulo 65537, zero standing for 65536 on both operands.
  function automatic idea_pkg::word_t mul_mod65537(idea_pkg::word_t x, idea_pkg::word_t y);
    longint unsigned ox;
    longint unsigned oy;
    longint unsigned prod;
    ox   = (x == '0) ? 64'd65536 : 64'(x);
    oy   = (y == '0) ? 64'd65536 : 64'(y);
    prod = (ox * oy) % 64'd65537;
    return prod[15:0];
  endfunction

  // Run all rounds of the round function; the middle words swap every round.
  function automatic idea_pkg::block_t encrypt_block(idea_pkg::block_t plain);
    idea_pkg::word_t w0, w1, w2, w3;
    idea_pkg::word_t a, b, c, d, e, f, g;
    int unsigned kidx;
    idea_pkg::word_t k [6];
    w0   = plain[63:48];
    w1   = plain[47:32];
    w2   = plain[31:16];
    w3   = plain[15:0];
    kidx = 0;
    for (int r = 0; r < RoundCount; r++) begin
      for (int j = 0; j < 6; j++) begin
        k[3'(j)] = KeyTable[6'(kidx % 56)];
        kidx = (kidx + 1) % 56;
      end
      a  = mul_mod65537(w0, k[0]);
      b  = w1 + k[1];
      c  = w2 + k[2];
      d  = mul_mod65537(w3, k[3]);
      e  = mul_mod65537(a ^ c, k[4]);
      f  = mul_mod65537((b ^ d) + e, k[5]);
      g  = e + f;
      w0 = a ^ f;
      w1 = c ^ f;
      w2 = b ^ g;
      w3 = d ^ g;
    end
    return {w0, w1, w2, w3};
  endfunction

  // Find the word whose product with the key wraps to 65536, returned as zero.
  function automatic idea_pkg::word_t zero_product_partner(idea_pkg::word_t key);
    for (int x = 1; x < 65536; x++) begin
      if (mul_mod65537(idea_pkg::word_t'(x), key) == '0) begin
        return idea_pkg::word_t'(x);
      end
    end
    return '0;
  endfunction

  // Offer one word at the falling edge, hold it until accepted.
  task automatic send_block(idea_pkg::block_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      blk_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    blk_in.valid <= 1'b1;
    blk_in.block <= blk;
    do @(posedge clk_i); while (!blk_in.ready);
    @(negedge clk_i);
  endtask

  // Draw a random block: mostly uniform, some from corner words, single bits or zero-product words.
  function automatic idea_pkg::block_t random_block(idea_pkg::word_t zp_first,
                                                    idea_pkg::word_t zp_last);
    idea_pkg::block_t blk;
    int unsigned mode;
    mode = $urandom_range(9);
    blk  = {$urandom, $urandom};
    if (mode == 6 || mode == 7) begin
      for (int w = 0; w < 4; w++) begin
        case ($urandom_range(3))
          0: blk[6'(w*16) +: 16] = 16'h0000;
          1: blk[6'(w*16) +: 16] = 16'hFFFF;
          2: blk[6'(w*16) +: 16] = 16'h0001;
          default: blk[6'(w*16) +: 16] = idea_pkg::word_t'($urandom);
        endcase
      end
    end else if (mode == 8) begin
      // Single bit set in zeros, or cleared in ones.
      blk = $urandom_range(1) ? '1 : '0;
      blk[6'($urandom_range(63))] ^= 1'b1;
    end else if (mode == 9) begin
      if ($urandom_range(1)) begin
        blk[63:48] = zp_first;
      end else begin
        blk[15:0] = zp_last;
      end
    end
    return blk;
  endfunction

  // Receiver: random ready, plus one long hold-off counted here.
  initial begin
    blk_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        blk_out.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        blk_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: predict on every accepted input word, check every result word.
  always @(posedge clk_i) begin
    idea_pkg::block_t want;
    bit               moved;
    moved = 1'b0;
    if (blk_in.valid && blk_in.ready) begin
      expected_cipher_q.push_back(encrypt_block(blk_in.block));
      blocks_in++;
      moved = 1'b1;
    end
    if (blk_in.valid && !blk_in.ready && hold_req && !hold_done) begin
      full_stall_cycles++;
    end
    if (blk_out.valid && blk_out.ready) begin
      moved = 1'b1;
      if (expected_cipher_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit) begin
          $display("[%0t] unexpected result word %h", $realtime, blk_out.block);
        end
      end else begin
        want = expected_cipher_q.pop_front();
        blocks_checked++;
        if (blk_out.block !== want) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("[%0t] block_out mismatch: expected %h, got %h",
                     $realtime, want, blk_out.block);
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, expected_cipher_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then three idle phases of random words.
  initial begin
    idea_pkg::block_t directed_rows [$];
    idea_pkg::word_t  zp_first;
    idea_pkg::word_t  zp_last;
    rst_ni       = 1'b0;
    blk_in.valid = 1'b0;
    blk_in.block = '0;

    zp_first = zero_product_partner(KeyTable[0]);
    zp_last  = zero_product_partner(KeyTable[3]);
    foreach (DirectedBlocks[i]) directed_rows.push_back(DirectedBlocks[i]);
    // First multiply of round one wraps to 65536 and comes out as zero in both rows, the last one in the first row too.
    directed_rows.push_back({zp_first, 16'h1111, 16'h2222, zp_last});
    directed_rows.push_back({zp_first, 16'hFFFF, 16'h0000, 16'h0001});

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 57;
    foreach (directed_rows[i]) begin
      send_block(directed_rows[i]);
      directed_count++;
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Stall the output while words keep coming so the pipe backs up.
          hold_req = 1'b1;
        end
      endcase
      for (int n = 0; n < RandomBlocks / 3; n++) begin
        send_block(random_block(zp_first, zp_last));
      end
    end
    blk_in.valid <= 1'b0;

    // Drain, then leave room for any stray result word.
    while (expected_cipher_q.size() != 0) @(negedge clk_i);
    repeat (PipeLatency + 16) @(negedge clk_i);

    $display("covered %0d blocks (%0d directed) over three idle mixes, %0d results checked",
             blocks_in, directed_count, blocks_checked);
    $display("input held off for %0d cycles while the output was stalled",
             full_stall_cycles);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
